### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;

  typedef enum logic [2:0] {
    K_ADD = 3'd0,
    K_SUB = 3'd1,
    K_MUL = 3'd2,
    K_DIV = 3'd3,
    K_CMP = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_DIVZ = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]                    kind;
    logic signed [FIELD_BITS-1:0]  a_num;
    logic signed [FIELD_BITS-1:0]  a_den;
    logic signed [FIELD_BITS-1:0]  b_num;
    logic signed [FIELD_BITS-1:0]  b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0]  res_num;
    logic [FIELD_BITS-2:0]         res_den;
    logic                          less_than;
    logic                          equal_to;
    logic [1:0]                    status;
  } out_item_t;

  // classified operands in sign / magnitude form
  typedef struct packed {
    logic [2:0]            kind;
    logic                  byp;
    status_e               st;
    logic                  aneg;
    logic [FIELD_BITS-1:0] amag;
    logic [FIELD_BITS-1:0] aden;
    logic                  bneg;
    logic [FIELD_BITS-1:0] bmag;
    logic [FIELD_BITS-1:0] bden;
  } q_item_t;

endpackage

### rtl/core/rau_front.sv
`timescale 1ns / 1ps
module rau_front #(
  parameter int W = rau_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  rau_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output rau_pkg::q_item_t  q_item
);
  import rau_pkg::*;

  q_item_t    mem [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  q_item_t    cls;
  logic       wr, rd;
  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] anm, adm, bnm, bdm;

  assign an  = in_data.a_num[W-1:0];
  assign ad  = in_data.a_den[W-1:0];
  assign bn  = in_data.b_num[W-1:0];
  assign bd  = in_data.b_den[W-1:0];
  assign anm = an[W-1] ? (~an + 1'b1) : an;
  assign adm = ad[W-1] ? (~ad + 1'b1) : ad;
  assign bnm = bn[W-1] ? (~bn + 1'b1) : bn;
  assign bdm = bd[W-1] ? (~bd + 1'b1) : bd;

  always_comb begin
    cls      = '0;
    cls.kind = in_data.kind;
    cls.st   = ST_OK;
    cls.amag = FIELD_BITS'(anm);
    cls.aden = FIELD_BITS'(adm);
    cls.bmag = FIELD_BITS'(bnm);
    cls.bden = FIELD_BITS'(bdm);
    cls.aneg = (an[W-1] != ad[W-1]) && (anm != '0);
    cls.bneg = (bn[W-1] != bd[W-1]) && (bnm != '0);
    if (in_data.kind > K_CMP) begin
      cls.byp = 1'b1;
    end else if (ad == '0 || bd == '0) begin
      cls.byp = 1'b1;
      cls.st  = ST_ZDEN;
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem[rp_r];
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= cls;
    end
  end

endmodule

### rtl/core/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
  parameter int W = rau_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  rau_pkg::q_item_t   q_item,
  output logic               empty,
  input  logic               pop,
  output rau_pkg::out_item_t out_data
);
  import rau_pkg::*;

  localparam int PW = 2 * W + 1;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_COMB, S_G0, S_G1, S_G2, S_DIV, S_CHK, S_OUT
  } state_t;

  state_t        state_r;
  q_item_t       ent_r;
  logic [PW-1:0] x1_r, x2_r, x3_r, p1_r, p2_r, p3_r;
  logic [W-1:0]  y1_r, y2_r, y3_r;
  logic [CW-1:0] cnt_r, sh_r;
  logic          neg_r;
  logic [PW-1:0] m_r, d_r, ga_r, gb_r, g_r;
  logic [PW:0]   rm_r, rd_r;
  out_item_t     res_r, out_r;
  logic          ov_r;

  logic [PW-1:0] cm, cd;
  logic          cn, n2;
  logic [PW:0]   tm, td;
  logic [W-1:0]  nv;
  out_item_t     st_item, cmp_item, chk_item;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign empty    = !ov_r;
  assign out_data = out_r;

  always_comb begin
    n2 = (ent_r.kind == K_SUB) ? (!ent_r.bneg && ent_r.bmag != '0) : ent_r.bneg;
    cm = p1_r;
    cd = p3_r;
    cn = ent_r.aneg != ent_r.bneg;
    if (ent_r.kind == K_ADD || ent_r.kind == K_SUB) begin
      if (ent_r.aneg == n2) begin
        cm = p1_r + p2_r;
        cn = n2;
      end else if (p1_r >= p2_r) begin
        cm = p1_r - p2_r;
        cn = ent_r.aneg;
      end else begin
        cm = p2_r - p1_r;
        cn = n2;
      end
    end
    tm = {rm_r[PW-1:0], m_r[PW-1]};
    td = {rd_r[PW-1:0], d_r[PW-1]};
    nv = neg_r ? (~m_r[W-1:0] + 1'b1) : m_r[W-1:0];
  end

  always_comb begin
    st_item        = '0;
    st_item.status = q_item.byp ? q_item.st : ST_DIVZ;

    cmp_item = '0;
    if (ent_r.aneg != ent_r.bneg) begin
      cmp_item.less_than = ent_r.aneg;
    end else begin
      cmp_item.less_than = ent_r.aneg ? (p1_r > p2_r) : (p1_r < p2_r);
      cmp_item.equal_to  = p1_r == p2_r;
    end

    chk_item = '0;
    if (m_r == '0) begin
      chk_item.res_den = 31'd1;
    end else if (d_r > HALF - 1'b1 || m_r > (neg_r ? HALF : HALF - 1'b1)) begin
      chk_item.status = ST_OVF;
    end else begin
      chk_item.res_num = FIELD_BITS'($signed(nv));
      chk_item.res_den = 31'(d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (pop && ov_r) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ent_r <= q_item;
            x1_r  <= PW'(q_item.amag[W-1:0]);
            x2_r  <= PW'(q_item.bmag[W-1:0]);
            x3_r  <= PW'(q_item.aden[W-1:0]);
            y1_r  <= (q_item.kind == K_MUL) ? q_item.bmag[W-1:0] : q_item.bden[W-1:0];
            y2_r  <= q_item.aden[W-1:0];
            y3_r  <= (q_item.kind == K_DIV) ? q_item.bmag[W-1:0] : q_item.bden[W-1:0];
            p1_r  <= '0;
            p2_r  <= '0;
            p3_r  <= '0;
            cnt_r <= '0;
            if (q_item.byp || (q_item.kind == K_DIV && q_item.bmag == '0)) begin
              res_r   <= st_item;
              state_r <= S_OUT;
            end else begin
              res_r   <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (y1_r[0]) p1_r <= p1_r + x1_r;
          if (y2_r[0]) p2_r <= p2_r + x2_r;
          if (y3_r[0]) p3_r <= p3_r + x3_r;
          x1_r  <= x1_r << 1;
          x2_r  <= x2_r << 1;
          x3_r  <= x3_r << 1;
          y1_r  <= y1_r >> 1;
          y2_r  <= y2_r >> 1;
          y3_r  <= y3_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(W - 1)) begin
            state_r <= S_COMB;
          end
        end
        S_COMB: begin
          if (ent_r.kind == K_CMP) begin
            res_r   <= cmp_item;
            state_r <= S_OUT;
          end else begin
            m_r     <= cm;
            d_r     <= cd;
            neg_r   <= cn;
            ga_r    <= cm;
            gb_r    <= cd;
            sh_r    <= '0;
            state_r <= S_G0;
          end
        end
        S_G0: begin
          if (ga_r == '0) begin
            g_r     <= gb_r;
            rm_r    <= '0;
            rd_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1;
            gb_r <= gb_r >> 1;
            sh_r <= sh_r + 1'b1;
          end else begin
            state_r <= S_G1;
          end
        end
        S_G1: begin
          if (!ga_r[0]) begin
            ga_r <= ga_r >> 1;
          end else begin
            state_r <= S_G2;
          end
        end
        S_G2: begin
          if (gb_r == '0) begin
            g_r     <= ga_r << sh_r;
            rm_r    <= '0;
            rd_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else if (!gb_r[0]) begin
            gb_r <= gb_r >> 1;
          end else if (ga_r > gb_r) begin
            ga_r <= gb_r;
            gb_r <= ga_r - gb_r;
          end else begin
            gb_r <= gb_r - ga_r;
          end
        end
        S_DIV: begin
          if (tm >= {1'b0, g_r}) begin
            rm_r <= tm - {1'b0, g_r};
            m_r  <= {m_r[PW-2:0], 1'b1};
          end else begin
            rm_r <= tm;
            m_r  <= {m_r[PW-2:0], 1'b0};
          end
          if (td >= {1'b0, g_r}) begin
            rd_r <= td - {1'b0, g_r};
            d_r  <= {d_r[PW-2:0], 1'b1};
          end else begin
            rd_r <= td;
            d_r  <= {d_r[PW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(PW - 1)) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          res_r   <= chk_item;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r) begin
            out_r   <= res_r;
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Exact fraction add, subtract, multiply, divide and compare with the result
// reduced to lowest terms. The front end classifies each item and queues up to
// two; the back end runs one item at a time: a shift-add multiply, a binary
// GCD on the 2*WORD_BITS+1-bit values, then a restoring divide of numerator
// and denominator by the GCD. Compares skip the GCD and the divide. Bypassed
// items (zero denominator, divide by zero, unused kinds) go straight to the
// output. A result left waiting on the output holds the back end until it is
// popped.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rau_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output rau_pkg::out_item_t out_data
);
  import rau_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  rau_front #(.W(WORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  rau_back #(.W(WORD_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status != ST_OK) |->
      (out_data.res_num == '0 && out_data.res_den == '0 &&
       !out_data.less_than && !out_data.equal_to))
    else $error("error result carries data");

  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.less_than && out_data.equal_to))
    else $error("less_than and equal_to both set");

  a_cmp_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.less_than || out_data.equal_to)) |->
      (out_data.res_den == '0 && out_data.status == ST_OK))
    else $error("compare result carries a fraction");

endmodule
